@@ design/fbpa_pkg.sv @@
// Shared widths, codes and reset values for the fixed block pool allocator.
package fbpa_pkg;

  // Field widths of the request, response and configuration channels.
  localparam int OFFSET_W    = 21;
  localparam int STATUS_W    = 2;
  localparam int INDEX_W     = 8;
  localparam int COUNT_W     = 9;
  localparam int BYTES_W     = 13;
  localparam int STRIDE_W    = 14;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 13;

  // Every block starts with a fixed-size header in front of its payload.
  localparam int HEADER_BYTES = 8;

  // Busy flags are stored in rows of this many bits.
  localparam int ROW_BITS = 16;
  localparam int BIT_W    = 4;

  localparam int MAX_BLOCKS_DEF = 256;

  // Register reset values.
  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 9'd256;
  localparam logic [BYTES_W-1:0] BLOCK_BYTES_RESET = 13'd64;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BYTES = 1'd1;

  // Request operation codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_BAD_OFFSET = 2'd2,
    ST_NOT_BUSY   = 2'd3
  } status_t;

endpackage

@@ design/fbpa_if.sv @@
// Request and response channel interfaces of the fixed block pool allocator.
interface fbpa_req_if;
  import fbpa_pkg::*;

  logic                valid;
  logic                ready;
  logic                func;
  logic [OFFSET_W-1:0] free_offset;

  modport source(output valid, func, free_offset, input ready);
  modport sink(input valid, func, free_offset, output ready);
endinterface

interface fbpa_rsp_if;
  import fbpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OFFSET_W-1:0] block_offset;
  logic [INDEX_W-1:0]  block_index;
  logic [COUNT_W-1:0]  free_count;

  modport source(output valid, status, block_offset, block_index, free_count, input ready);
  modport sink(input valid, status, block_offset, block_index, free_count, output ready);
endinterface

@@ design/fbpa_div.sv @@
// Iterative restoring divider that recovers a block index from a payload offset.
module fbpa_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [fbpa_pkg::OFFSET_W-1:0]    dividend,
  input  logic [fbpa_pkg::STRIDE_W-1:0]    divisor,
  output logic                             done,
  output logic [fbpa_pkg::OFFSET_W-1:0]    quot,
  output logic [fbpa_pkg::STRIDE_W-1:0]    rem
);
  import fbpa_pkg::*;

  localparam int CNT_W = $clog2(OFFSET_W + 1);

  logic                active;
  logic [CNT_W-1:0]    cnt;
  logic [STRIDE_W-1:0] dsr;
  logic [STRIDE_W:0]   trial;
  logic [STRIDE_W:0]   diff;
  logic                ge;

  // One quotient bit per cycle: shift in the next dividend bit, subtract if it fits.
  assign trial = {rem, quot[OFFSET_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CNT_W'(OFFSET_W);
        quot   <= dividend;
        rem    <= '0;
        dsr    <= divisor;
      end else if (active) begin
        quot <= {quot[OFFSET_W-2:0], ge};
        rem  <= ge ? diff[STRIDE_W-1:0] : trial[STRIDE_W-1:0];
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/fbpa_flags.sv @@
// Busy-flag memory: one bit per block, packed into rows, registered read.
module fbpa_flags #(
  parameter int ROWS = 16,
  parameter int RW   = 4
) (
  input  logic                          clk,
  input  logic [RW-1:0]                 rd_addr,
  output logic [fbpa_pkg::ROW_BITS-1:0] rd_data,
  input  logic                          we,
  input  logic [RW-1:0]                 wr_addr,
  input  logic [fbpa_pkg::ROW_BITS-1:0] wr_data
);
  import fbpa_pkg::*;

  logic [ROW_BITS-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/fixed_block_pool_allocator.sv @@
// Top level of the fixed block pool allocator: sequencer, registers and response stage.
//
// Requests arrive on req (func 0 allocates, func 1 frees the block whose payload
// offset is free_offset); each request gives exactly one beat on rsp with status,
// block_offset, block_index and free_count. A beat moves when valid and ready are
// high at a rising edge. cfg_we / cfg_index / cfg_data write block_count (index 0)
// or block_bytes (index 1); any write reinitializes the pool.
// One request is handled at a time; ready is high only while the sequencer idles
// and no register write is under way. An allocate scans the busy flags one 16-bit
// row at a time, a read state and a check state per row, up to the first free
// block; the payload offset is then worked out in a multiply state before the
// response state. An allocate on an empty pool or a free below the header goes
// straight from idle to the response state. A free runs the offset through a
// one-bit-per-cycle divider, 21 steps, then reads and checks the block's flag row;
// when the divide rejects the offset, it goes straight to the response state.
// After reset and after each configuration write, a clearing pass writes every flag
// row to zero, one row per cycle, with ready low. A finished result sits in the
// output register; while the receiver stalls, the next request is still accepted
// and worked on, and only its own result waits until the output register has been
// taken.
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fbpa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data,
  fbpa_req_if.sink                        req,
  fbpa_rsp_if.source                      rsp
);
  import fbpa_pkg::*;

  // Flag storage geometry.
  localparam int ROWS_RAW = (MAX_BLOCKS + ROW_BITS - 1) / ROW_BITS;
  localparam int ROWS     = (ROWS_RAW < 2) ? 2 : ROWS_RAW;
  localparam int RW       = $clog2(ROWS);
  // Global block index is a row number followed by a bit position.
  localparam int GIW      = RW + BIT_W;
  // Counts run up to the pool size, and must also hold the block_count register.
  localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);
  localparam int NW       = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int GW       = (GIW > NW) ? GIW : NW;
  localparam int CW       = (NW > OFFSET_W) ? NW : OFFSET_W;
  localparam int PW       = GIW + STRIDE_W;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MUL,
    S_DIV,
    S_FREE_RD,
    S_FREE_CHK,
    S_RESP
  } state_t;

  state_t               state;
  logic [RW-1:0]        row;
  logic [BIT_W-1:0]     bit_sel;
  logic [COUNT_W-1:0]   block_count;
  logic [BYTES_W-1:0]   block_bytes;
  logic [NW-1:0]        free_blocks;
  logic [NW-1:0]        pool_n;
  logic [NW-1:0]        count_ext;
  logic [STRIDE_W-1:0]  stride;

  // Result being built for the current request.
  status_t              res_status;
  logic [OFFSET_W-1:0]  res_off;
  logic [GIW-1:0]       res_idx;

  // Output register.
  logic                 rsp_valid;
  logic                 rsp_load;
  status_t              rsp_status;
  logic [OFFSET_W-1:0]  rsp_off;
  logic [INDEX_W-1:0]   rsp_idx;
  logic [COUNT_W-1:0]   rsp_count;

  // Divider hookup.
  logic                 div_start;
  logic [OFFSET_W-1:0]  div_dividend;
  logic                 div_done;
  logic [OFFSET_W-1:0]  div_quot;
  logic [STRIDE_W-1:0]  div_rem;

  // Flag memory hookup and scan logic.
  logic [ROW_BITS-1:0]  rd_data;
  logic                 mem_we;
  logic [ROW_BITS-1:0]  mem_wdata;
  logic [ROW_BITS-1:0]  row_mask;
  logic [ROW_BITS-1:0]  row_view;
  logic                 scan_hit;
  logic [BIT_W-1:0]     scan_bit;

  // Effective pool size: block_count limited to the storage.
  assign count_ext = NW'(block_count);
  assign pool_n    = (count_ext > NW'(MAX_BLOCKS)) ? NW'(MAX_BLOCKS) : count_ext;
  assign stride    = STRIDE_W'(block_bytes) + STRIDE_W'(HEADER_BYTES);

  assign req.ready        = (state == S_IDLE) && !cfg_we;
  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.block_offset = rsp_off;
  assign rsp.block_index  = rsp_idx;
  assign rsp.free_count   = rsp_count;

  // The finished result moves into the output register once that is free.
  assign rsp_load = (state == S_RESP) && !cfg_we && (!rsp_valid || rsp.ready);

  // A free with an offset at or above the header size starts the divider in the cycle the request is taken.
  assign div_start    = (state == S_IDLE) && req.valid && (req.func == FUNC_FREE) &&
                        (req.free_offset >= OFFSET_W'(HEADER_BYTES)) && !cfg_we;
  assign div_dividend = req.free_offset - OFFSET_W'(HEADER_BYTES);

  fbpa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (stride),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  fbpa_flags #(
    .ROWS (ROWS),
    .RW   (RW)
  ) u_flags (
    .clk     (clk),
    .rd_addr (row),
    .rd_data (rd_data),
    .we      (mem_we),
    .wr_addr (row),
    .wr_data (mem_wdata)
  );

  // Flags of blocks beyond the pool size read as busy, so the scan skips them.
  always_comb begin
    for (int b = 0; b < ROW_BITS; b++) begin
      row_mask[b] = GW'({row, BIT_W'(b)}) < GW'(pool_n);
    end
    row_view = rd_data | ~row_mask;
    scan_hit = (row_view != '1);
    scan_bit = '0;
    for (int b = ROW_BITS - 1; b >= 0; b--) begin
      if (!row_view[b]) begin
        scan_bit = BIT_W'(b);
      end
    end
  end

  // Flag memory writes: clearing pass, marking a block busy, releasing a block.
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      S_SCAN_CHK: begin
        mem_we    = scan_hit;
        mem_wdata = rd_data | (ROW_BITS'(1) << scan_bit);
      end
      S_FREE_CHK: begin
        mem_we    = rd_data[bit_sel];
        mem_wdata = rd_data & ~(ROW_BITS'(1) << bit_sel);
      end
      default: begin
        mem_we    = 1'b0;
        mem_wdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      row         <= '0;
      block_count <= BLOCK_COUNT_RESET;
      block_bytes <= BLOCK_BYTES_RESET;
      free_blocks <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      // The output register is either reloaded or emptied in a cycle.
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      if (cfg_we) begin
        // Any register write restarts the clearing pass.
        unique case (cfg_index)
          CFG_BLOCK_COUNT: block_count <= cfg_data[COUNT_W-1:0];
          CFG_BLOCK_BYTES: block_bytes <= cfg_data[BYTES_W-1:0];
        endcase
        state <= S_CLEAR;
        row   <= '0;
      end else begin
        unique case (state)
          S_CLEAR: begin
            row <= row + RW'(1);
            if (row == RW'(ROWS - 1)) begin
              free_blocks <= pool_n;
              state       <= S_IDLE;
            end
          end

          S_IDLE: begin
            res_off <= '0;
            res_idx <= '0;
            if (req.valid) begin
              if (req.func == FUNC_ALLOC) begin
                if (free_blocks == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_RESP;
                end else begin
                  row   <= '0;
                  state <= S_SCAN_RD;
                end
              end else if (req.free_offset < OFFSET_W'(HEADER_BYTES)) begin
                res_status <= ST_BAD_OFFSET;
                state      <= S_RESP;
              end else begin
                state <= S_DIV;
              end
            end
          end

          S_SCAN_RD: begin
            state <= S_SCAN_CHK;
          end

          S_SCAN_CHK: begin
            if (scan_hit) begin
              bit_sel     <= scan_bit;
              res_idx     <= {row, scan_bit};
              free_blocks <= free_blocks - NW'(1);
              state       <= S_MUL;
            end else if (row == RW'(ROWS - 1)) begin
              res_status <= ST_EMPTY;
              state      <= S_RESP;
            end else begin
              row   <= row + RW'(1);
              state <= S_SCAN_RD;
            end
          end

          S_MUL: begin
            // Payload offset of the new block: index times stride, past the header.
            res_off    <= OFFSET_W'(PW'(res_idx) * PW'(stride) + PW'(HEADER_BYTES));
            res_status <= ST_OK;
            state      <= S_RESP;
          end

          S_DIV: begin
            if (div_done) begin
              if (div_rem != '0 || CW'(div_quot) >= CW'(pool_n)) begin
                res_status <= ST_BAD_OFFSET;
                state      <= S_RESP;
              end else begin
                {row, bit_sel} <= GIW'(div_quot);
                res_idx        <= GIW'(div_quot);
                state          <= S_FREE_RD;
              end
            end
          end

          S_FREE_RD: begin
            state <= S_FREE_CHK;
          end

          S_FREE_CHK: begin
            if (rd_data[bit_sel]) begin
              free_blocks <= free_blocks + NW'(1);
              res_status  <= ST_OK;
            end else begin
              res_status <= ST_NOT_BUSY;
            end
            state <= S_RESP;
          end

          S_RESP: begin
            // Hand the result over once the output register is free.
            if (rsp_load) begin
              rsp_status <= res_status;
              rsp_off    <= res_off;
              rsp_idx    <= INDEX_W'(res_idx);
              rsp_count  <= COUNT_W'(free_blocks);
              state      <= S_IDLE;
            end
          end

          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule

@@ bench/tb_fixed_block_pool_allocator.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the fixed block pool allocator: scoreboard class and stimulus.

// One response beat as the bench expects or sees it.
typedef struct packed {
  fbpa_pkg::status_t                  status;
  logic [fbpa_pkg::OFFSET_W-1:0]      block_offset;
  logic [fbpa_pkg::INDEX_W-1:0]       block_index;
  logic [fbpa_pkg::COUNT_W-1:0]       free_count;
} pool_outcome_t;

// Shadow of the pool: registers, busy flags and free count, plus the
// queue of responses still owed by the block.
class pool_scoreboard;
  logic [fbpa_pkg::COUNT_W-1:0] block_count;
  logic [fbpa_pkg::BYTES_W-1:0] block_bytes;
  bit                           busy [fbpa_pkg::MAX_BLOCKS_DEF];
  int unsigned                  free_blocks;
  pool_outcome_t                owed_q [$];
  int                           errors;

  function new();
    block_count = fbpa_pkg::BLOCK_COUNT_RESET;
    block_bytes = fbpa_pkg::BLOCK_BYTES_RESET;
    errors      = 0;
    clear_pool();
  endfunction

  // Counts above the pool's capacity are clamped to it.
  function int unsigned pool_size();
    return (block_count > fbpa_pkg::MAX_BLOCKS_DEF) ? fbpa_pkg::MAX_BLOCKS_DEF : block_count;
  endfunction

  function int unsigned stride();
    return block_bytes + fbpa_pkg::HEADER_BYTES;
  endfunction

  function void clear_pool();
    foreach (busy[i]) busy[i] = 1'b0;
    free_blocks = pool_size();
  endfunction

  function void write_reg(logic [fbpa_pkg::CFG_INDEX_W-1:0] index,
                          logic [fbpa_pkg::CFG_DATA_W-1:0] data);
    if (index == fbpa_pkg::CFG_BLOCK_COUNT) begin
      block_count = data[fbpa_pkg::COUNT_W-1:0];
    end else begin
      block_bytes = data;
    end
    clear_pool();
  endfunction

  function int pending();
    return owed_q.size();
  endfunction

  // Applies one accepted request to the shadow pool and queues its response.
  function void note_request(logic func, logic [fbpa_pkg::OFFSET_W-1:0] offset);
    pool_outcome_t res;
    int unsigned   n;
    int unsigned   rel;
    int unsigned   idx;
    res        = '0;
    res.status = fbpa_pkg::ST_OK;
    n          = pool_size();
    if (func == fbpa_pkg::FUNC_ALLOC) begin
      res.status = fbpa_pkg::ST_EMPTY;
      if (free_blocks != 0) begin
        for (int i = 0; i < n; i++) begin
          if (!busy[i]) begin
            busy[i]          = 1'b1;
            free_blocks--;
            res.status       = fbpa_pkg::ST_OK;
            res.block_offset = fbpa_pkg::OFFSET_W'(i * stride() + fbpa_pkg::HEADER_BYTES);
            res.block_index  = fbpa_pkg::INDEX_W'(i);
            break;
          end
        end
      end
    end else if (offset < fbpa_pkg::HEADER_BYTES) begin
      res.status = fbpa_pkg::ST_BAD_OFFSET;
    end else begin
      rel = offset - fbpa_pkg::HEADER_BYTES;
      idx = rel / stride();
      if ((rel % stride()) != 0 || idx >= n) begin
        res.status = fbpa_pkg::ST_BAD_OFFSET;
      end else if (!busy[idx]) begin
        res.status      = fbpa_pkg::ST_NOT_BUSY;
        res.block_index = fbpa_pkg::INDEX_W'(idx);
      end else begin
        busy[idx]       = 1'b0;
        free_blocks++;
        res.block_index = fbpa_pkg::INDEX_W'(idx);
      end
    end
    res.free_count = fbpa_pkg::COUNT_W'(free_blocks);
    owed_q.push_back(res);
  endfunction

  function void compare(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 50) $error("%s mismatch: expected %0d, got %0d", field, want, got);
    end
  endfunction

  function void check_result(pool_outcome_t got);
    pool_outcome_t want;
    if (owed_q.size() == 0) begin
      errors++;
      if (errors <= 50) $error("response beat with no request outstanding");
      return;
    end
    want = owed_q.pop_front();
    compare("status", want.status, got.status);
    compare("block_offset", want.block_offset, got.block_offset);
    compare("block_index", want.block_index, got.block_index);
    compare("free_count", want.free_count, got.free_count);
  endfunction
endclass

module tb_fixed_block_pool_allocator;
  import fbpa_pkg::*;

  localparam int HALF_PERIOD = 5;
  // Quiet cycles before a register write; the block answers every request,
  // so this only has to cover the last response leaving the output stage.
  localparam int CFG_PAUSE   = 8;
  // Cycles watched after the last expected beat for stray responses.
  localparam int TAIL_CYCLES = 40;
  // Long receiver stall that lets the request side back up.
  localparam int HOLD_CYCLES = 300;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  fbpa_req_if req ();
  fbpa_rsp_if rsp ();

  fixed_block_pool_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

  pool_scoreboard sb = new();

  // Each side walks through runs of beats; in a steady run it never idles,
  // otherwise it may wait before every beat, for a gap drawn at random.
  int tx_run = 0;
  int rx_run = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  function automatic int draw_gap(inout int run, inout bit steady);
    if (run == 0) begin
      run    = $urandom_range(8, 40);
      steady = ($urandom_range(0, 3) == 0);
    end
    run--;
    return steady ? 0 : $urandom_range(0, 16);
  endfunction

  // Offers one request beat and waits for the handshake. Entered and left at
  // a falling edge; valid is only lowered when a gap really follows, so a
  // back-to-back beat keeps it high without a second assignment in the step.
  task automatic send_req(input logic func, input logic [OFFSET_W-1:0] offset);
    int gap;
    gap = draw_gap(tx_run, tx_steady);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid       <= 1'b1;
    req.func        <= func;
    req.free_offset <= offset;
    do @(posedge clk); while (req.ready !== 1'b1);
    sb.note_request(func, offset);
    @(negedge clk);
  endtask

  // Stops offering requests and waits until every owed response has been taken.
  task automatic drain();
    req.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Register writes go in only while the sequencer idles; ready drops during
  // the clearing pass that every write starts, so waiting for it also
  // covers the pass that follows the previous write.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    repeat (CFG_PAUSE) @(negedge clk);
    while (req.ready !== 1'b1) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(index, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input int unsigned count, input int unsigned bytes);
    drain();
    write_reg(CFG_BLOCK_COUNT, CFG_DATA_W'(count));
    write_reg(CFG_BLOCK_BYTES, CFG_DATA_W'(bytes));
  endtask

  // Draws one request. Most frees hand back a block that is really busy so
  // the pool cycles through fill and drain; the rest probe double frees,
  // offsets under the header, offsets off a block boundary, indexes just
  // past the pool and fully random offsets.
  task automatic next_item(input int alloc_pct, output logic func,
                           output logic [OFFSET_W-1:0] offset);
    int unsigned n;
    int unsigned st;
    int unsigned roll;
    int unsigned top;
    int unsigned taken [$];
    n      = sb.pool_size();
    st     = sb.stride();
    top    = (n > 0) ? n - 1 : 0;
    roll   = $urandom_range(0, 99);
    func   = FUNC_FREE;
    offset = OFFSET_W'($urandom);
    if (roll < alloc_pct) begin
      func = FUNC_ALLOC;
    end else begin
      for (int i = 0; i < n; i++) if (sb.busy[i]) taken.push_back(i);
      roll = $urandom_range(0, 99);
      if (roll < 60 && taken.size() != 0) begin
        offset = OFFSET_W'(taken[$urandom_range(0, taken.size() - 1)] * st + HEADER_BYTES);
      end else if (roll < 75) begin
        offset = OFFSET_W'($urandom_range(0, top) * st + HEADER_BYTES);
      end else if (roll < 83) begin
        offset = OFFSET_W'($urandom_range(0, HEADER_BYTES - 1));
      end else if (roll < 91) begin
        offset = OFFSET_W'($urandom_range(0, top) * st + HEADER_BYTES + $urandom_range(1, st - 1));
      end else if (roll < 96) begin
        offset = OFFSET_W'(n * st + HEADER_BYTES);
      end
    end
  endtask

  task automatic run_phase(input int items, input int alloc_pct);
    logic                func;
    logic [OFFSET_W-1:0] offset;
    for (int k = 0; k < items; k++) begin
      next_item(alloc_pct, func, offset);
      send_req(func, offset);
    end
  endtask

  // Request side: reset, directed corner cases, then randomized phases over
  // a spread of pool sizes and payload sizes, the extremes among them.
  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = CFG_BLOCK_COUNT;
    cfg_data        = '0;
    req.valid       = 1'b0;
    req.func        = FUNC_ALLOC;
    req.free_offset = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: 256 blocks of 64 bytes, a stride of 72. The first
    // allocate carries an all-ones offset, which it must ignore.
    send_req(FUNC_ALLOC, '1);
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_FREE, 21'd8);            // block 0 back
    send_req(FUNC_FREE, 21'd8);            // second free of the same block
    send_req(FUNC_FREE, 21'd0);            // inside the header
    send_req(FUNC_FREE, 21'd7);            // last header byte
    send_req(FUNC_FREE, 21'd9);            // off the block boundary
    send_req(FUNC_FREE, 21'd18368);        // last block, never allocated
    send_req(FUNC_FREE, 21'd18440);        // one block past the pool
    send_req(FUNC_FREE, '1);               // largest offset
    send_req(FUNC_FREE, 21'd80);           // block 1 back
    send_req(FUNC_ALLOC, 21'h0AAAAA);

    // One block with an empty payload: the stride is the header alone.
    configure(1, 0);
    send_req(FUNC_ALLOC, 21'h155555);
    send_req(FUNC_ALLOC, '0);              // pool exhausted
    send_req(FUNC_FREE, 21'd16);           // index beyond a one-block pool
    send_req(FUNC_FREE, 21'd8);

    // A pool of zero blocks: allocate is always empty, every free is bad.
    configure(0, 8191);
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_FREE, 21'd8);

    configure(1, 0);
    run_phase(60, 50);
    configure(2, 8191);
    run_phase(60, 50);
    configure(5, 1);
    run_phase(80, 55);
    configure(16, 4096);
    run_phase(100, 55);
    // Full pool with the widest stride reaches the top of the offset range.
    configure(256, 8191);
    run_phase(120, 70);
    configure(0, 17);
    run_phase(30, 50);
    // Counts over the capacity are clamped to it.
    configure(300, 100);
    run_phase(100, 60);
    configure(511, 7);
    run_phase(60, 50);
    configure(37, 4095);
    run_phase(120, 55);
    configure(256, 64);
    run_phase(120, 80);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("PASS fixed_block_pool_allocator");
    end else begin
      $display("FAIL fixed_block_pool_allocator");
    end
    $finish;
  end

  // Response side: takes beats with random stalls and checks each one.
  // Twice during the run it stalls for a long stretch so the output stage
  // and the sequencer fill up and the request channel backs off.
  initial begin
    int            gap;
    int            beats;
    pool_outcome_t got;
    rsp.ready = 1'b0;
    beats     = 0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      gap = draw_gap(rx_run, rx_steady);
      if (beats == 350 || beats == 700) gap += HOLD_CYCLES;
      if (gap != 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (rsp.valid !== 1'b1);
      got.status       = status_t'(rsp.status);
      got.block_offset = rsp.block_offset;
      got.block_index  = rsp.block_index;
      got.free_count   = rsp.free_count;
      sb.check_result(got);
      beats++;
      @(negedge clk);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #5ms;
    $display("FAIL fixed_block_pool_allocator");
    $finish;
  end

endmodule
